// File: rtl/core/bfha_pkg.sv
// Shared types, defaults and codes of the best-fit heap allocator.
`timescale 1ns / 1ps
package bfha_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_HEADER_BYTES = 24;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        action;
        logic [15:0] request_size;
        logic [15:0] free_address;
    } cmd_t;

    typedef struct packed {
        logic [15:0] result_address;
        logic [1:0]  status;
        logic [16:0] heap_top;
    } rsp_t;

endpackage

// File: rtl/core/best_fit_heap_allocator_top.sv
// Best-fit heap allocator: block table in one synchronous memory and its sequencer.
`timescale 1ns / 1ps
// Sequence: an allocate or free takes one scan of the table, then, where needed, a shift
//   pass over the entries above the touched block, then a write to the response register.
// Throughput: one command at a time; the one write port and one read port of the table
//   memory set the pace, one entry per cycle in each pass.
// Reset: entry count and heap top clear at once; the table memory is not cleared.
module best_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS   = bfha_pkg::DEF_MAX_BLOCKS,
    parameter int HEAP_BYTES   = bfha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  bfha_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bfha_pkg::rsp_t rsp
);
    import bfha_pkg::*;

    // index into the table, count of entries, block size, wide arithmetic
    localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(HEAP_BYTES) + 1;
    localparam int AW = ((SW > 17) ? SW : 17) + 1;
    localparam int DW = SW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SHUP  = 3'd3;
    localparam logic [2:0] S_WREM  = 3'd4;
    localparam logic [2:0] S_WBEST = 3'd5;
    localparam logic [2:0] S_SHDN  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] HEAP    = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] ADR_MAX = AW'(16'hFFFF);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    // table memory: {used, size} per entry, one write and one registered read a cycle
    logic [DW-1:0] mem [MAX_BLOCKS];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] top_reg, top_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    // per-command working registers
    logic          act_reg, act_next;
    logic [AW-1:0] need_reg, need_next;
    logic [15:0]   faddr_reg, faddr_next;
    logic [AW-1:0] off_reg, off_next;
    logic          best_v_reg, best_v_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [AW-1:0] best_off_reg, best_off_next;
    logic [AW-1:0] best_sz_reg, best_sz_next;
    logic          found_reg, found_next;
    logic [CW-1:0] fidx_reg, fidx_next;
    logic [AW-1:0] fsz_reg, fsz_next;
    logic          prv_used_reg, prv_used_next;
    logic [AW-1:0] prv_sz_reg, prv_sz_next;
    logic          nxt_v_reg, nxt_v_next;
    logic          nxt_used_reg, nxt_used_next;
    logic [AW-1:0] nxt_sz_reg, nxt_sz_next;
    logic [1:0]    shr_reg, shr_next;
    logic          split_reg, split_next;
    logic [15:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;

    // decoded view of the entry that arrives from the memory this cycle
    logic          w_used;
    logic [AW-1:0] w_sz;
    logic [AW-1:0] ap_addr, bf_addr, m_sz;
    logic          nf, pf;
    logic [CW-1:0] j0, s_idx;

    assign w_used  = rd_data_reg[SW];
    assign w_sz    = AW'(rd_data_reg[SW-1:0]);
    assign ap_addr = AW'(top_reg) + HDR;
    assign bf_addr = best_off_reg + HDR;
    assign nf      = nxt_v_reg && !nxt_used_reg;
    assign pf      = (fidx_reg != '0) && !prv_used_reg;
    assign m_sz    = fsz_reg + (nf ? nxt_sz_reg : '0) + (pf ? prv_sz_reg : '0);
    assign j0      = fidx_reg + CNT_ONE + CW'(nf);
    assign s_idx   = fidx_reg - CW'(pf);

    always_comb
    begin
        logic [AW-1:0] top_ext;
        top_ext        = AW'(top_reg);
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        act_next       = act_reg;
        need_next      = need_reg;
        faddr_next     = faddr_reg;
        off_next       = off_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        best_off_next  = best_off_reg;
        best_sz_next   = best_sz_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        fsz_next       = fsz_reg;
        prv_used_next  = prv_used_reg;
        prv_sz_next    = prv_sz_reg;
        nxt_v_next     = nxt_v_reg;
        nxt_used_next  = nxt_used_reg;
        nxt_sz_next    = nxt_sz_reg;
        shr_next       = shr_reg;
        split_next     = split_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = idx_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next    = cmd.action;
                    need_next   = AW'(cmd.request_size) + HDR;
                    faddr_next  = cmd.free_address;
                    off_next    = '0;
                    best_v_next = 1'b0;
                    found_next  = 1'b0;
                    nxt_v_next  = 1'b0;
                    prv_used_next = 1'b1;
                    idx_next    = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle, consume the entry read the cycle before
                if (idx_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + CNT_ONE;
                end
                else if (!pend_reg)
                begin
                    state_next = S_DEC;
                end
                if (pend_reg)
                begin
                    off_next = off_reg + w_sz;
                    if (act_reg == ACT_ALLOC)
                    begin
                        if (!w_used && w_sz >= need_reg && (!best_v_reg || w_sz < best_sz_reg))
                        begin
                            best_v_next   = 1'b1;
                            best_idx_next = pidx_reg;
                            best_off_next = off_reg;
                            best_sz_next  = w_sz;
                        end
                    end
                    else if (!found_reg)
                    begin
                        if (w_used && (off_reg + HDR) == AW'(faddr_reg))
                        begin
                            found_next = 1'b1;
                            fidx_next  = pidx_reg;
                            fsz_next   = w_sz;
                        end
                        else
                        begin
                            prv_used_next = w_used;
                            prv_sz_next   = w_sz;
                        end
                    end
                    else if (!nxt_v_reg && pidx_reg == fidx_reg + CNT_ONE)
                    begin
                        nxt_v_next    = 1'b1;
                        nxt_used_next = w_used;
                        nxt_sz_next   = w_sz;
                    end
                end
            end

            S_DEC:
            begin
                res_addr_next = '0;
                res_st_next   = ST_OK;
                state_next    = S_FIN;
                if (act_reg == ACT_ALLOC)
                begin
                    if (!best_v_reg)
                    begin
                        // append at the heap top
                        if (count_reg >= CNT_MAX || need_reg > HEAP - top_ext
                            || ap_addr > ADR_MAX)
                        begin
                            res_st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            mem_wa        = count_reg[IW-1:0];
                            mem_wd        = {1'b1, need_reg[SW-1:0]};
                            count_next    = count_reg + CNT_ONE;
                            top_next      = top_reg + need_reg[SW-1:0];
                            res_addr_next = ap_addr[15:0];
                        end
                    end
                    else if (bf_addr > ADR_MAX)
                    begin
                        res_st_next = ST_FULL;
                    end
                    else
                    begin
                        res_addr_next = bf_addr[15:0];
                        if (best_sz_reg != need_reg)
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                res_st_next   = ST_FULL;
                                res_addr_next = '0;
                            end
                            else
                            begin
                                split_next = 1'b1;
                                idx_next   = count_reg - CNT_ONE;
                                state_next = S_SHUP;
                            end
                        end
                        else
                        begin
                            split_next = 1'b0;
                            state_next = S_WBEST;
                        end
                    end
                end
                else if (!found_reg)
                begin
                    res_st_next = ST_NOT_FOUND;
                end
                else if (j0 == count_reg)
                begin
                    // merged block is the last one: drop it and lower the top
                    top_next   = top_reg - m_sz[SW-1:0];
                    count_next = s_idx;
                end
                else
                begin
                    mem_we   = 1'b1;
                    mem_wa   = s_idx[IW-1:0];
                    mem_wd   = {1'b0, m_sz[SW-1:0]};
                    shr_next = {1'b0, nf} + {1'b0, pf};
                    idx_next = j0;
                    if (nf || pf)
                    begin
                        state_next = S_SHDN;
                    end
                end
            end

            S_SHUP:
            begin
                // move entries above the best fit up by one, top first
                if (idx_reg > best_idx_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg - CNT_ONE;
                end
                else if (!pend_reg)
                begin
                    state_next = S_WREM;
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = IW'(pidx_reg + CNT_ONE);
                    mem_wd = rd_data_reg;
                end
            end

            S_WREM:
            begin
                mem_we     = 1'b1;
                mem_wa     = IW'(best_idx_reg + CNT_ONE);
                mem_wd     = {1'b0, SW'(best_sz_reg - need_reg)};
                state_next = S_WBEST;
            end

            S_WBEST:
            begin
                mem_we     = 1'b1;
                mem_wa     = best_idx_reg[IW-1:0];
                mem_wd     = {1'b1, need_reg[SW-1:0]};
                count_next = count_reg + CW'(split_reg);
                state_next = S_FIN;
            end

            S_SHDN:
            begin
                // close the gap left by merged entries, bottom first
                if (idx_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                    idx_next  = idx_reg + CNT_ONE;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(shr_reg);
                    state_next = S_FIN;
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = IW'(pidx_reg - CW'(shr_reg));
                    mem_wd = rd_data_reg;
                end
            end

            S_FIN:
            begin
                // hold until the response register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.result_address = res_addr_reg;
                    rsp_next.status         = res_st_reg;
                    rsp_next.heap_top       = top_ext[16:0];
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            top_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pidx_reg     <= pidx_next;
        rsp_reg      <= rsp_next;
        act_reg      <= act_next;
        need_reg     <= need_next;
        faddr_reg    <= faddr_next;
        off_reg      <= off_next;
        best_v_reg   <= best_v_next;
        best_idx_reg <= best_idx_next;
        best_off_reg <= best_off_next;
        best_sz_reg  <= best_sz_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        fsz_reg      <= fsz_next;
        prv_used_reg <= prv_used_next;
        prv_sz_reg   <= prv_sz_next;
        nxt_v_reg    <= nxt_v_next;
        nxt_used_reg <= nxt_used_next;
        nxt_sz_reg   <= nxt_sz_next;
        shr_reg      <= shr_next;
        split_reg    <= split_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
    end

    // take a new command only between commands; the response register decouples the output
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/bfha_checker.sv
// Port checker for the best-fit heap allocator and its bind.
`timescale 1ns / 1ps
module bfha_checker #(
    parameter int HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES
) (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input bfha_pkg::cmd_t cmd,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input bfha_pkg::rsp_t rsp
);
    import bfha_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                       || rsp.status == ST_NOT_FOUND))
        else $error("bad status code");

    a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.result_address == 16'd0))
        else $error("address on a failed beat");

    a_addr_past_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.result_address != 16'd0)
            |-> (32'(rsp.result_address) >= 32'(HEADER_BYTES)))
        else $error("address below header size");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response beat changed");

endmodule

bind best_fit_heap_allocator_top bfha_checker #(.HEADER_BYTES(HEADER_BYTES)) u_bfha_checker (.*);
